// File: rtl/ctd_pkg.sv
// Shared types and constants for the chunked transfer decoder.
// No dependencies; imported by ctd_step and chunked_transfer_decoder.
package ctd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_DATA_CR = 3'd2,
        PH_DATA_LF = 3'd3,
        PH_TRAILER = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Parser control state, everything except the size/length counter
    typedef struct packed {
        phase_t  phase;
        logic    digit_seen;
        logic    space_after_digits;
        logic    in_extension;
        logic    cr_pending;
        logic    line_has_colon;
        logic    line_empty;
        status_t final_status;
    } ctd_ctrl_t;

    localparam ctd_ctrl_t CTRL_RESET = '{
        phase:              PH_SIZE,
        digit_seen:         1'b0,
        space_after_digits: 1'b0,
        in_extension:       1'b0,
        cr_pending:         1'b0,
        line_has_colon:     1'b0,
        line_empty:         1'b1,
        final_status:       ST_BUSY
    };

endpackage

// File: rtl/ctd_step.sv
// Next-state logic of the chunked body parser: one byte per evaluation.
// Depends on ctd_pkg.
module ctd_step
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  ctd_ctrl_t              cur_ctrl,
    input  logic [SIZE_BITS-1:0]   cur_count,
    input  logic [7:0]             in_byte,
    input  logic                   start_req,
    output ctd_ctrl_t              nxt_ctrl,
    output logic [SIZE_BITS-1:0]   nxt_count,
    output logic                   body_valid,
    output logic [7:0]             body_byte
);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    ctd_ctrl_t            base_ctrl;
    logic [SIZE_BITS-1:0] base_count;
    logic                 is_hex;
    logic [3:0]           hex_nib;

    // hex digit decode
    always_comb
    begin
        is_hex  = 1'b1;
        hex_nib = 4'd0;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
            hex_nib = 4'(in_byte - 8'h30);
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
            hex_nib = 4'(in_byte - 8'h57);
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
            hex_nib = 4'(in_byte - 8'h37);
        else
            is_hex = 1'b0;
    end

    always_comb
    begin
        base_ctrl  = start_req ? CTRL_RESET : cur_ctrl;
        base_count = start_req ? '0 : cur_count;
        nxt_ctrl   = base_ctrl;
        nxt_count  = base_count;
        body_valid = 1'b0;
        body_byte  = 8'd0;

        if (base_ctrl.final_status == ST_BUSY)
        begin
            unique case (base_ctrl.phase)
                PH_SIZE:
                begin
                    if (base_ctrl.cr_pending)
                    begin
                        if (in_byte != CH_LF || !base_ctrl.digit_seen)
                            nxt_ctrl.final_status = ST_BAD;
                        else
                        begin
                            nxt_ctrl.cr_pending = 1'b0;
                            if (base_count == '0)
                            begin
                                nxt_ctrl.phase          = PH_TRAILER;
                                nxt_ctrl.line_empty     = 1'b1;
                                nxt_ctrl.line_has_colon = 1'b0;
                            end
                            else
                                nxt_ctrl.phase = PH_DATA;
                        end
                    end
                    else if (in_byte == CH_CR)
                        nxt_ctrl.cr_pending = 1'b1;
                    else if (base_ctrl.in_extension)
                        nxt_ctrl = base_ctrl;
                    else if (in_byte == CH_SEMI)
                        nxt_ctrl.in_extension = 1'b1;
                    else if (in_byte == CH_SPACE || in_byte == CH_TAB)
                    begin
                        if (base_ctrl.digit_seen)
                            nxt_ctrl.space_after_digits = 1'b1;
                    end
                    else if (!is_hex || base_ctrl.space_after_digits)
                        nxt_ctrl.final_status = ST_BAD;
                    else if (base_count[SIZE_BITS-1 -: 4] != 4'd0)
                        nxt_ctrl.final_status = ST_BAD;   // size overflow
                    else
                    begin
                        nxt_count           = {base_count[SIZE_BITS-5:0], hex_nib};
                        nxt_ctrl.digit_seen = 1'b1;
                    end
                end

                PH_DATA:
                begin
                    body_valid = 1'b1;
                    body_byte  = in_byte;
                    nxt_count  = base_count - SIZE_BITS'(1);
                    if (base_count == SIZE_BITS'(1))
                        nxt_ctrl.phase = PH_DATA_CR;
                end

                PH_DATA_CR:
                begin
                    if (in_byte == CH_CR)
                        nxt_ctrl.phase = PH_DATA_LF;
                    else
                        nxt_ctrl.final_status = ST_BAD;
                end

                PH_DATA_LF:
                begin
                    if (in_byte == CH_LF)
                    begin
                        // back to a fresh size line; trailer flags untouched
                        nxt_ctrl.phase              = PH_SIZE;
                        nxt_ctrl.digit_seen         = 1'b0;
                        nxt_ctrl.space_after_digits = 1'b0;
                        nxt_ctrl.in_extension       = 1'b0;
                        nxt_ctrl.cr_pending         = 1'b0;
                        nxt_count                   = '0;
                    end
                    else
                        nxt_ctrl.final_status = ST_BAD;
                end

                PH_TRAILER:
                begin
                    if (base_ctrl.cr_pending)
                    begin
                        if (in_byte != CH_LF)
                            nxt_ctrl.final_status = ST_BAD;
                        else
                        begin
                            nxt_ctrl.cr_pending = 1'b0;
                            if (base_ctrl.line_empty)
                                nxt_ctrl.final_status = ST_DONE;
                            else if (!base_ctrl.line_has_colon)
                                nxt_ctrl.final_status = ST_BAD;
                            else
                            begin
                                nxt_ctrl.line_empty     = 1'b1;
                                nxt_ctrl.line_has_colon = 1'b0;
                            end
                        end
                    end
                    else if (in_byte == CH_CR)
                        nxt_ctrl.cr_pending = 1'b1;
                    else
                    begin
                        nxt_ctrl.line_empty = 1'b0;
                        if (in_byte == CH_COLON)
                            nxt_ctrl.line_has_colon = 1'b1;
                    end
                end

                default:
                    nxt_ctrl.final_status = ST_BAD;
            endcase
        end
    end

endmodule

// File: rtl/chunked_transfer_decoder.sv
// Top level of the chunked transfer decoder: input register, parser state,
// result register. Depends on ctd_pkg and ctd_step.
//
//   channel | signals                          | direction | beat
//   --------+----------------------------------+-----------+------------------------------
//   in      | in_valid in_ready                | sink      | data_byte, start_req
//   out     | out_valid out_ready              | source    | body_valid, body_byte, status
//
// One beat in gives exactly one beat out; an accepted beat passes through the
// input register and then the result register, where it is offered on out.
// Sustained rate is one byte per cycle unless out stalls; the loop that sets it
// is the parser state update in ctd_step (SIZE_BITS-wide shift/decrement and compare).
// rst_n clears the parser to the start of a size line, status in progress.
// A stall on out holds the result register and the input register; in_ready
// drops only when both are full and out_ready is low.
module chunked_transfer_decoder
    import ctd_pkg::*;
#(
    parameter int SIZE_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       start_req,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       body_valid,
    output logic [7:0] body_byte,
    output logic [1:0] status
);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // parser state
    ctd_ctrl_t            ctrl_reg;
    ctd_ctrl_t            ctrl_next;
    logic [SIZE_BITS-1:0] count_reg;
    logic [SIZE_BITS-1:0] count_next;

    // result register
    logic       out_vld_reg;
    logic       body_vld_reg;
    logic [7:0] body_byte_reg;
    status_t    status_reg;

    logic       step_valid;
    logic [7:0] step_byte;
    logic       advance;

    // the registered byte moves into the result register when that is free
    // or being emptied this cycle
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;

    ctd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .cur_ctrl   (ctrl_reg),
        .cur_count  (count_reg),
        .in_byte    (in_byte_reg),
        .start_req  (in_start_reg),
        .nxt_ctrl   (ctrl_next),
        .nxt_count  (count_next),
        .body_valid (step_valid),
        .body_byte  (step_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            ctrl_reg     <= CTRL_RESET;
            count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
            begin
                ctrl_reg  <= ctrl_next;
                count_reg <= count_next;
            end
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg  <= data_byte;
            in_start_reg <= start_req;
        end
        if (advance)
        begin
            body_vld_reg  <= step_valid;
            body_byte_reg <= step_byte;
            status_reg    <= ctrl_next.final_status;
        end
    end

    assign out_valid  = out_vld_reg;
    assign body_valid = body_vld_reg;
    assign body_byte  = body_byte_reg;
    assign status     = status_reg;

    // payload bytes only come out while the message is still in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && body_valid |-> status == ST_BUSY)
        else $error("payload byte with final status");

    // data phase is entered only with a nonzero remaining length
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_reg.phase == PH_DATA |-> count_reg != '0)
        else $error("data phase with zero count");

    // backpressure only when both stages are full and the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_vld_reg && out_vld_reg && !out_ready)
        else $error("input stalled without cause");

    // a final status sticks until a new message starts
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !in_start_reg && ctrl_reg.final_status != ST_BUSY
        |=> $stable(ctrl_reg))
        else $error("sticky status changed");

endmodule
